/* rtl/core/trr_pkg.sv */
`default_nettype none

package trr_pkg;

  // Signed width of a pixel coordinate; the tile origin never exceeds 2047.
  localparam int PXW     = 12;
  localparam int PIX_W   = 11;
  localparam int WGT_W   = 26;
  localparam int TIDX_W  = 8;
  localparam int NUM_EDG = 3;

  // Width of a coordinate difference, wide enough for pixel minus vertex.
  function automatic int diff_w(input int cb);
    return ((cb > PXW) ? cb : PXW) + 1;
  endfunction

  // Accumulator width: exact edge value, never narrower than the output weight.
  function automatic int acc_w(input int cb);
    return ((2 * diff_w(cb) + 1) > WGT_W) ? (2 * diff_w(cb) + 1) : WGT_W;
  endfunction

  // Bits of one triangle setup record handed from the front to the back.
  function automatic int setup_w(input int cb);
    return NUM_EDG * acc_w(cb) + 2 * NUM_EDG * diff_w(cb) + 4 * cb + 2 * PXW;
  endfunction

  // Edge e runs from vertex edge_a(e) to vertex edge_b(e).
  function automatic int edge_a(input int e);
    return (e == 2) ? 0 : e + 1;
  endfunction

  function automatic int edge_b(input int e);
    return (e == 0) ? 2 : e - 1;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/trr_fifo.sv */
`default_nettype none

module trr_fifo import trr_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic                  valid_o,
  output logic [WIDTH-1:0]      rdata_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign valid_o = (count_q != '0);
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("setup queue written while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("setup queue read while empty");
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("setup queue count out of range");
`endif

endmodule

`default_nettype wire

/* rtl/core/trr_front.sv */
`default_nettype none

module trr_front import trr_pkg::*; #(
  parameter  int COORD_BITS = 12,
  parameter  int TILE_SIZE  = 8,
  localparam int SW         = setup_w(COORD_BITS)
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic signed [COORD_BITS-1:0] vertex0_x_i,
  input  wire logic signed [COORD_BITS-1:0] vertex0_y_i,
  input  wire logic signed [COORD_BITS-1:0] vertex1_x_i,
  input  wire logic signed [COORD_BITS-1:0] vertex1_y_i,
  input  wire logic signed [COORD_BITS-1:0] vertex2_x_i,
  input  wire logic signed [COORD_BITS-1:0] vertex2_y_i,
  input  wire logic [TIDX_W-1:0]            tile_col_i,
  input  wire logic [TIDX_W-1:0]            tile_row_i,
  output logic                              push_o,
  output logic [SW-1:0]                     setup_o,
  input  wire logic                         full_i
);

  localparam int CW  = COORD_BITS;
  localparam int DW  = diff_w(COORD_BITS);
  localparam int AW  = acc_w(COORD_BITS);
  localparam int PRW = 2 * DW;

  typedef struct packed {
    logic [NUM_EDG-1:0][AW-1:0] w_init;
    logic [NUM_EDG-1:0][DW-1:0] step_x;
    logic [NUM_EDG-1:0][DW-1:0] step_y;
    logic [CW-1:0]              lo_x;
    logic [CW-1:0]              hi_x;
    logic [CW-1:0]              lo_y;
    logic [CW-1:0]              hi_y;
    logic [PXW-1:0]             base_x;
    logic [PXW-1:0]             base_y;
  } setup_t;

  // Stage 1: captured triangle.
  logic                  s1_vld_q;
  logic signed [CW-1:0]  vx_q [NUM_EDG];
  logic signed [CW-1:0]  vy_q [NUM_EDG];
  logic [TIDX_W-1:0]     tcol_q;
  logic [TIDX_W-1:0]     trow_q;

  // Stage 2: edge deltas, origin offsets, bounding box.
  logic                  s2_vld_q;
  logic signed [DW-1:0]  ex_q  [NUM_EDG];
  logic signed [DW-1:0]  ey_q  [NUM_EDG];
  logic signed [DW-1:0]  pxa_q [NUM_EDG];
  logic signed [DW-1:0]  pya_q [NUM_EDG];
  logic signed [CW-1:0]  lo_x_q, hi_x_q, lo_y_q, hi_y_q;
  logic signed [PXW-1:0] base_x_q, base_y_q;

  // Stage 3: edge function products at the tile origin.
  logic                  s3_vld_q;
  logic signed [PRW-1:0] m1_q [NUM_EDG];
  logic signed [PRW-1:0] m2_q [NUM_EDG];
  logic signed [DW-1:0]  ex3_q [NUM_EDG];
  logic signed [DW-1:0]  ey3_q [NUM_EDG];
  logic signed [CW-1:0]  lo_x3_q, hi_x3_q, lo_y3_q, hi_y3_q;
  logic signed [PXW-1:0] base_x3_q, base_y3_q;

  logic                  accept, adv2;
  logic signed [PXW-1:0] base_x_c, base_y_c;
  logic signed [CW-1:0]  lo_x_c, hi_x_c, lo_y_c, hi_y_c;
  logic signed [DW-1:0]  ex_c  [NUM_EDG];
  logic signed [DW-1:0]  ey_c  [NUM_EDG];
  logic signed [DW-1:0]  pxa_c [NUM_EDG];
  logic signed [DW-1:0]  pya_c [NUM_EDG];
  setup_t                setup;

  // A setup stage moves on when the one after it is empty or moving too; stage 3 needs a non-full queue.
  assign push_o     = s3_vld_q && !full_i;
  assign adv2       = s2_vld_q && (!s3_vld_q || push_o);
  assign in_stall_o = s1_vld_q && s2_vld_q && !adv2;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    base_x_c = PXW'(int'(tcol_q) * TILE_SIZE);
    base_y_c = PXW'(int'(trow_q) * TILE_SIZE);
    lo_x_c = vx_q[0];
    hi_x_c = vx_q[0];
    lo_y_c = vy_q[0];
    hi_y_c = vy_q[0];
    for (int v = 1; v < NUM_EDG; v++) begin
      if (vx_q[v] < lo_x_c) lo_x_c = vx_q[v];
      if (vx_q[v] > hi_x_c) hi_x_c = vx_q[v];
      if (vy_q[v] < lo_y_c) lo_y_c = vy_q[v];
      if (vy_q[v] > hi_y_c) hi_y_c = vy_q[v];
    end
    for (int e = 0; e < NUM_EDG; e++) begin
      ex_c[e]  = DW'(vx_q[edge_b(e)]) - DW'(vx_q[edge_a(e)]);
      ey_c[e]  = DW'(vy_q[edge_b(e)]) - DW'(vy_q[edge_a(e)]);
      pxa_c[e] = DW'(base_x_c) - DW'(vx_q[edge_a(e)]);
      pya_c[e] = DW'(base_y_c) - DW'(vy_q[edge_a(e)]);
    end
  end

  // Moving one pixel right adds -dy to an edge value, one row down adds dx.
  always_comb begin
    for (int e = 0; e < NUM_EDG; e++) begin
      setup.w_init[e] = AW'(m1_q[e]) - AW'(m2_q[e]);
      setup.step_x[e] = -ey3_q[e];
      setup.step_y[e] = ex3_q[e];
    end
    setup.lo_x   = lo_x3_q;
    setup.hi_x   = hi_x3_q;
    setup.lo_y   = lo_y3_q;
    setup.hi_y   = hi_y3_q;
    setup.base_x = base_x3_q;
    setup.base_y = base_y3_q;
  end

  assign setup_o = setup;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
    end else begin
      if (accept) begin
        s1_vld_q <= 1'b1;
      end else if (s1_vld_q && !in_stall_o) begin
        s1_vld_q <= 1'b0;
      end
      if (s1_vld_q && !in_stall_o) begin
        s2_vld_q <= 1'b1;
      end else if (adv2) begin
        s2_vld_q <= 1'b0;
      end
      if (adv2) begin
        s3_vld_q <= 1'b1;
      end else if (push_o) begin
        s3_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      vx_q[0] <= vertex0_x_i;
      vy_q[0] <= vertex0_y_i;
      vx_q[1] <= vertex1_x_i;
      vy_q[1] <= vertex1_y_i;
      vx_q[2] <= vertex2_x_i;
      vy_q[2] <= vertex2_y_i;
      tcol_q  <= tile_col_i;
      trow_q  <= tile_row_i;
    end
    if (s1_vld_q && !in_stall_o) begin
      for (int e = 0; e < NUM_EDG; e++) begin
        ex_q[e]  <= ex_c[e];
        ey_q[e]  <= ey_c[e];
        pxa_q[e] <= pxa_c[e];
        pya_q[e] <= pya_c[e];
      end
      lo_x_q   <= lo_x_c;
      hi_x_q   <= hi_x_c;
      lo_y_q   <= lo_y_c;
      hi_y_q   <= hi_y_c;
      base_x_q <= base_x_c;
      base_y_q <= base_y_c;
    end
    if (adv2) begin
      for (int e = 0; e < NUM_EDG; e++) begin
        m1_q[e]  <= PRW'(ex_q[e]) * PRW'(pya_q[e]);
        m2_q[e]  <= PRW'(ey_q[e]) * PRW'(pxa_q[e]);
        ex3_q[e] <= ex_q[e];
        ey3_q[e] <= ey_q[e];
      end
      lo_x3_q   <= lo_x_q;
      hi_x3_q   <= hi_x_q;
      lo_y3_q   <= lo_y_q;
      hi_y3_q   <= hi_y_q;
      base_x3_q <= base_x_q;
      base_y3_q <= base_y_q;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/trr_back.sv */
`default_nettype none

module trr_back import trr_pkg::*; #(
  parameter  int COORD_BITS = 12,
  parameter  int TILE_SIZE  = 8,
  localparam int SW         = setup_w(COORD_BITS)
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               q_valid_i,
  input  wire logic [SW-1:0]      q_data_i,
  output logic                    pop_o,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [PIX_W-1:0]        pixel_x_o,
  output logic [PIX_W-1:0]        pixel_y_o,
  output logic                    covered_o,
  output logic signed [WGT_W-1:0] weight0_o,
  output logic signed [WGT_W-1:0] weight1_o,
  output logic signed [WGT_W-1:0] weight2_o,
  output logic                    last_o
);

  localparam int CW    = COORD_BITS;
  localparam int DW    = diff_w(COORD_BITS);
  localparam int AW    = acc_w(COORD_BITS);
  localparam int CNT_W = $clog2(TILE_SIZE);

  typedef struct packed {
    logic [NUM_EDG-1:0][AW-1:0] w_init;
    logic [NUM_EDG-1:0][DW-1:0] step_x;
    logic [NUM_EDG-1:0][DW-1:0] step_y;
    logic [CW-1:0]              lo_x;
    logic [CW-1:0]              hi_x;
    logic [CW-1:0]              lo_y;
    logic [CW-1:0]              hi_y;
    logic [PXW-1:0]             base_x;
    logic [PXW-1:0]             base_y;
  } setup_t;

  setup_t              cur_q;
  setup_t              nxt;
  logic                busy_q;
  logic [CNT_W-1:0]    col_q, row_q;
  logic signed [AW-1:0] w_q   [NUM_EDG];
  logic signed [AW-1:0] wrow_q [NUM_EDG];

  logic                out_valid_q;
  logic [PIX_W-1:0]    pix_x_q, pix_y_q;
  logic                cov_q, last_q;
  logic [WGT_W-1:0]    wout_q [NUM_EDG];

  logic                out_adv, step, col_last, row_last, end_item;
  logic [PXW-1:0]      px_c, py_c;
  logic                in_box, cov_c;

  assign nxt      = setup_t'(q_data_i);
  assign out_adv  = !out_valid_q || !out_stall_i;
  assign step     = busy_q && out_adv;
  assign col_last = (col_q == CNT_W'(TILE_SIZE - 1));
  assign row_last = (row_q == CNT_W'(TILE_SIZE - 1));
  assign end_item = step && col_last && row_last;
  assign pop_o    = q_valid_i && (!busy_q || end_item);

  always_comb begin
    px_c   = cur_q.base_x + PXW'(col_q);
    py_c   = cur_q.base_y + PXW'(row_q);
    in_box = ($signed({1'b0, px_c}) >= $signed(cur_q.lo_x)) &&
             ($signed({1'b0, px_c}) <= $signed(cur_q.hi_x)) &&
             ($signed({1'b0, py_c}) >= $signed(cur_q.lo_y)) &&
             ($signed({1'b0, py_c}) <= $signed(cur_q.hi_y));
    cov_c  = in_box;
    for (int e = 0; e < NUM_EDG; e++) begin
      if (w_q[e][AW-1]) cov_c = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      col_q       <= '0;
      row_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_adv) begin
        out_valid_q <= busy_q;
      end
      if (pop_o) begin
        busy_q <= 1'b1;
        col_q  <= '0;
        row_q  <= '0;
      end else if (step) begin
        if (col_last) begin
          col_q <= '0;
          if (row_last) begin
            row_q  <= '0;
            busy_q <= 1'b0;
          end else begin
            row_q <= row_q + 1'b1;
          end
        end else begin
          col_q <= col_q + 1'b1;
        end
      end
    end
  end

  // Edge values walk incrementally: across a row by step_x, row to row by step_y.
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= nxt;
      for (int e = 0; e < NUM_EDG; e++) begin
        w_q[e]    <= $signed(nxt.w_init[e]);
        wrow_q[e] <= $signed(nxt.w_init[e]);
      end
    end else if (step) begin
      for (int e = 0; e < NUM_EDG; e++) begin
        if (col_last) begin
          w_q[e]    <= wrow_q[e] + AW'($signed(cur_q.step_y[e]));
          wrow_q[e] <= wrow_q[e] + AW'($signed(cur_q.step_y[e]));
        end else begin
          w_q[e] <= w_q[e] + AW'($signed(cur_q.step_x[e]));
        end
      end
    end
    if (step) begin
      pix_x_q <= px_c[PIX_W-1:0];
      pix_y_q <= py_c[PIX_W-1:0];
      cov_q   <= cov_c;
      last_q  <= col_last && row_last;
      for (int e = 0; e < NUM_EDG; e++) begin
        wout_q[e] <= w_q[e][WGT_W-1:0];
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign pixel_x_o   = pix_x_q;
  assign pixel_y_o   = pix_y_q;
  assign covered_o   = cov_q;
  assign weight0_o   = wout_q[0];
  assign weight1_o   = wout_q[1];
  assign weight2_o   = wout_q[2];
  assign last_o      = last_q;

`ifndef ASSERT_OFF
  a_last_on_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    end_item |=> out_valid_o && last_o)
    else $error("final pixel of a tile not flagged as last");
  a_idle_rewound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> (col_q == '0) && (row_q == '0))
    else $error("pixel counters not rewound while idle");
  a_mid_tile_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && !end_item |=> busy_q)
    else $error("tile walk stopped before its last pixel");
`endif

endmodule

`default_nettype wire

/* rtl/core/triangle_tile_rasterizer.sv */
// Channel  | Direction | Handshake                  | Payload
// ---------+-----------+----------------------------+----------------------------------------
// in       | input     | in_valid_i / in_stall_o    | vertex{0,1,2}_{x,y}_i, tile_col_i/_row_i
// out      | output    | out_valid_o / out_stall_i  | pixel_x/y_o, covered_o, weight0..2_o, last_o
//
// Each triangle yields TILE_SIZE*TILE_SIZE results from the pixel walker, one per cycle
// unless the output stalls.
// The three-stage setup pipeline and a two-entry setup queue let new triangles be
// taken while the walker is busy; each passes the setup stages, the queue and the walker's output register.
// Reset clears all valid flags and counters at once; there is no clearing pass.
// A stall on the output freezes the walker; input stalls only when setup and queue are full.
`default_nettype none

module triangle_tile_rasterizer import trr_pkg::*; #(
  parameter int TILE_SIZE  = 8,
  parameter int COORD_BITS = 12
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic signed [COORD_BITS-1:0] vertex0_x_i,
  input  wire logic signed [COORD_BITS-1:0] vertex0_y_i,
  input  wire logic signed [COORD_BITS-1:0] vertex1_x_i,
  input  wire logic signed [COORD_BITS-1:0] vertex1_y_i,
  input  wire logic signed [COORD_BITS-1:0] vertex2_x_i,
  input  wire logic signed [COORD_BITS-1:0] vertex2_y_i,
  input  wire logic [TIDX_W-1:0]            tile_col_i,
  input  wire logic [TIDX_W-1:0]            tile_row_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic [PIX_W-1:0]                  pixel_x_o,
  output logic [PIX_W-1:0]                  pixel_y_o,
  output logic                              covered_o,
  output logic signed [WGT_W-1:0]           weight0_o,
  output logic signed [WGT_W-1:0]           weight1_o,
  output logic signed [WGT_W-1:0]           weight2_o,
  output logic                              last_o
);

  localparam int SW = setup_w(COORD_BITS);

  logic          push, full, pop, q_valid;
  logic [SW-1:0] setup_in, setup_out;

  trr_front #(
    .COORD_BITS(COORD_BITS),
    .TILE_SIZE (TILE_SIZE)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .vertex0_x_i(vertex0_x_i),
    .vertex0_y_i(vertex0_y_i),
    .vertex1_x_i(vertex1_x_i),
    .vertex1_y_i(vertex1_y_i),
    .vertex2_x_i(vertex2_x_i),
    .vertex2_y_i(vertex2_y_i),
    .tile_col_i (tile_col_i),
    .tile_row_i (tile_row_i),
    .push_o     (push),
    .setup_o    (setup_in),
    .full_i     (full)
  );

  trr_fifo #(
    .WIDTH(SW),
    .DEPTH(2)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .wdata_i(setup_in),
    .full_o (full),
    .pop_i  (pop),
    .valid_o(q_valid),
    .rdata_o(setup_out)
  );

  trr_back #(
    .COORD_BITS(COORD_BITS),
    .TILE_SIZE (TILE_SIZE)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_data_i   (setup_out),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .pixel_x_o  (pixel_x_o),
    .pixel_y_o  (pixel_y_o),
    .covered_o  (covered_o),
    .weight0_o  (weight0_o),
    .weight1_o  (weight1_o),
    .weight2_o  (weight2_o),
    .last_o     (last_o)
  );

endmodule

`default_nettype wire
